@@ rtl/dspv_pkg.sv @@
// shared types, codes and month table for the date string parse and validate unit
`timescale 1ns / 1ps
package dspv_pkg;

   localparam int CH_W     = 8;
   localparam int NUM_W    = 16;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int STATUS_W = 2;
   localparam int ORDER_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [NUM_W-1:0] YEAR_MIN       = 16'd1980;
   localparam logic [NUM_W-1:0] YEAR_MAX       = 16'd2099;
   localparam logic [NUM_W-1:0] CENTURY_19     = 16'd1900;
   localparam logic [NUM_W-1:0] CENTURY_20     = 16'd2000;
   localparam logic [NUM_W-1:0] WINDOW_PIVOT   = 16'd80;
   localparam logic [NUM_W-1:0] TWO_DIGIT_MAX  = 16'd99;

   localparam logic [CH_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CH_W-1:0] CHAR_DASH  = 8'h2d;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 2'd0;
   localparam logic [CH_W-1:0]    SEP_RESET   = 8'd47;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DATE_ORDER = 1'b0,
      CSR_SEPARATOR  = 1'b1
   } csr_index_type;

   typedef enum logic [ORDER_W-1:0] {
      ORDER_MDY = 2'd0,
      ORDER_DMY = 2'd1,
      ORDER_YMD = 2'd2
   } order_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_KEEP    = 2'd0,
      STATUS_VALID   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_NUM   = 3'd1,
      PH_SEP   = 3'd2,
      PH_DONE  = 3'd3,
      PH_FAIL  = 3'd4
   } phase_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] lim;
      case (m)
         4'd1:    lim = 5'd31;
         4'd2:    lim = leap ? 5'd29 : 5'd28;
         4'd3:    lim = 5'd31;
         4'd4:    lim = 5'd30;
         4'd5:    lim = 5'd31;
         4'd6:    lim = 5'd30;
         4'd7:    lim = 5'd31;
         4'd8:    lim = 5'd31;
         4'd9:    lim = 5'd30;
         4'd10:   lim = 5'd31;
         4'd11:   lim = 5'd30;
         4'd12:   lim = 5'd31;
         default: lim = 5'd0;
      endcase
      return lim;
   endfunction

endpackage

@@ rtl/date_string_parse_validate_unit.sv @@
// date string parse and validate unit: character stream in, one date result per string
//
// usage
//   req channel: one character per transaction on req_ch; a zero byte ends the string
//   rsp channel: one transaction per terminator, carrying status, year, month, day
//   csr port: csr_wr_en with csr_index 0 writes date_order, 1 writes separator_char
//   throughput: one character per cycle, with no bubbles between strings, while no
//     terminator waits in the input register on a stalled receiver
//   path: input register, then the parse/validate logic into the result register
//   only characters are registered and decoded; the date check runs once per
//     string off the parse registers, set by the single result register
//   receiver stall: the result register holds; non-terminator characters keep
//     flowing, and a terminator waits in the input register, which raises req_stall
//   reset: synchronous, clears parse state, empties both registers, and sets
//     date_order to 0 and separator_char to 47
//
`timescale 1ns / 1ps
module date_string_parse_validate_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dspv_pkg::CH_W-1:0]     req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dspv_pkg::STATUS_W-1:0] rsp_status,
   output logic [dspv_pkg::YEAR_W-1:0]   rsp_year,
   output logic [dspv_pkg::MONTH_W-1:0]  rsp_month,
   output logic [dspv_pkg::DAY_W-1:0]    rsp_day,
   input  logic                          csr_wr_en,
   input  logic [dspv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dspv_pkg::CH_W-1:0]     csr_wdata
);
   import dspv_pkg::*;

   // configuration
   logic [ORDER_W-1:0] order_ff;
   logic [CH_W-1:0]    sep_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CH_W-1:0]    ch_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [1:0]         field_ff, field_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic [NUM_W-1:0]   first_ff, first_in;
   logic [NUM_W-1:0]   second_ff, second_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;

   logic               accept;
   logic               is_term;
   logic               fire;
   logic               is_digit;
   logic               is_sep;
   logic [NUM_W-1:0]   dv;
   logic [NUM_W-1:0]   acc_next;

   logic [NUM_W-1:0]   y_raw, m_raw, d_raw, y_full;
   logic               leap;
   logic [DAY_W-1:0]   lim;
   logic               parsed_ok;
   logic               date_ok;

   assign is_term   = (ch_ff == CHAR_NUL);
   assign fire      = in_valid_ff && (!is_term || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign is_digit = (ch_ff >= CHAR_ZERO) && (ch_ff <= CHAR_NINE);
   assign is_sep   = (ch_ff == CHAR_SLASH) || (ch_ff == CHAR_DASH) || (ch_ff == sep_ff);
   assign dv       = {{(NUM_W-4){1'b0}}, 4'(ch_ff - CHAR_ZERO)};
   assign acc_next = {acc_ff[NUM_W-4:0], 3'b000} + {acc_ff[NUM_W-2:0], 1'b0} + dv;

   // field selection and date check, used on the terminator only
   always_comb begin
      case (order_ff)
         ORDER_DMY: begin
            d_raw = first_ff;
            m_raw = second_ff;
            y_raw = acc_ff;
         end
         ORDER_YMD: begin
            y_raw = first_ff;
            m_raw = second_ff;
            d_raw = acc_ff;
         end
         default: begin
            m_raw = first_ff;
            d_raw = second_ff;
            y_raw = acc_ff;
         end
      endcase
      if (y_raw <= TWO_DIGIT_MAX) begin
         y_full = y_raw + ((y_raw >= WINDOW_PIVOT) ? CENTURY_19 : CENTURY_20);
      end else begin
         y_full = y_raw;
      end
      // inside 1980..2099 the only century year is 2000, which is a leap year
      leap      = (y_full[1:0] == 2'b00);
      lim       = month_days(m_raw[MONTH_W-1:0], leap);
      parsed_ok = (phase_ff == PH_DONE) || ((phase_ff == PH_NUM) && (field_ff == 2'd2));
      date_ok   = parsed_ok
                  && (m_raw >= 16'd1) && (m_raw <= 16'd12)
                  && (d_raw >= 16'd1) && (d_raw <= {{(NUM_W-DAY_W){1'b0}}, lim})
                  && (y_full >= YEAR_MIN) && (y_full <= YEAR_MAX);
   end

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      field_in     = field_ff;
      acc_in       = acc_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      status_in    = status_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      in_valid_in  = accept || (in_valid_ff && !fire);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         if (is_term) begin
            rsp_valid_in = 1'b1;
            year_in      = '0;
            month_in     = '0;
            day_in       = '0;
            if (phase_ff == PH_START) begin
               status_in = STATUS_KEEP;
            end else if (date_ok) begin
               status_in = STATUS_VALID;
               year_in   = y_full[YEAR_W-1:0];
               month_in  = m_raw[MONTH_W-1:0];
               day_in    = d_raw[DAY_W-1:0];
            end else begin
               status_in = STATUS_INVALID;
            end
            phase_in  = PH_START;
            field_in  = 2'd0;
            acc_in    = '0;
            first_in  = '0;
            second_in = '0;
         end else begin
            case (phase_ff)
               PH_START, PH_SEP: begin
                  if (is_digit) begin
                     acc_in   = dv;
                     phase_in = PH_NUM;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_NUM: begin
                  if (is_digit) begin
                     acc_in = acc_next;
                  end else if (field_ff == 2'd2) begin
                     phase_in = PH_DONE;
                  end else if (is_sep) begin
                     if (field_ff == 2'd0) begin
                        first_in = acc_ff;
                     end else begin
                        second_in = acc_ff;
                     end
                     field_in = field_ff + 2'd1;
                     acc_in   = '0;
                     phase_in = PH_SEP;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= ORDER_RESET;
         sep_ff       <= SEP_RESET;
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_START;
         field_ff     <= 2'd0;
         acc_ff       <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DATE_ORDER: order_ff <= csr_wdata[ORDER_W-1:0];
               CSR_SEPARATOR:  sep_ff   <= csr_wdata;
               default:        sep_ff   <= sep_ff;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         field_ff     <= field_in;
         acc_ff       <= acc_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff <= req_ch;
      end
      status_ff <= status_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_year   = year_ff;
   assign rsp_month  = month_ff;
   assign rsp_day    = day_ff;

   a_fields_zero_unless_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_VALID)) |->
         ((rsp_year == '0) && (rsp_month == '0) && (rsp_day == '0)))
      else $error("non-valid result carries a date");

   a_valid_date_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_VALID)) |->
         ((rsp_year >= 12'd1980) && (rsp_year <= 12'd2099) && (rsp_month >= 4'd1)
          && (rsp_month <= 4'd12) && (rsp_day >= 5'd1)))
      else $error("valid result out of range");

   a_restart_after_term: assert property (@(posedge clock) disable iff (reset)
      (fire && is_term) |=> ((phase_ff == PH_START) && (field_ff == 2'd0) && rsp_valid_ff))
      else $error("parse state not cleared after terminator");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_term && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked terminator");

endmodule

@@ tb/date_string_parse_validate_unit_tb.sv @@
// testbench for the date string parse and validate unit: predicted results, random traffic
`timescale 1ns / 1ps
module date_string_parse_validate_unit_tb;
   import dspv_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_ITEMS   = 480;

   typedef struct packed {
      status_type          status;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
   } date_result_type;

   typedef enum {ROLE_MONTH, ROLE_DAY, ROLE_YEAR} date_role_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CH_W-1:0]       req_ch;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [YEAR_W-1:0]     rsp_year;
   logic [MONTH_W-1:0]    rsp_month;
   logic [DAY_W-1:0]      rsp_day;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CH_W-1:0]       csr_wdata;

   date_result_type       expected_dates[$];
   logic [CH_W-1:0]       string_chars[$];

   logic [ORDER_W-1:0]    order_setting = ORDER_RESET;
   logic [CH_W-1:0]       separator_setting = SEP_RESET;
   phase_type             scan_phase = PH_START;
   logic [1:0]            field_count = 2'd0;
   logic [NUM_W-1:0]      digits_value = '0;
   logic [NUM_W-1:0]      first_value = '0;
   logic [NUM_W-1:0]      second_value = '0;

   int failures = 0;
   int burst_left = 0;
   int chars_sent = 0;
   int hold_request = 0;

   date_string_parse_validate_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   task automatic clear_scan();
      scan_phase = PH_START;
      field_count = 2'd0;
      digits_value = '0;
      first_value = '0;
      second_value = '0;
   endtask

   function automatic date_result_type judge_date();
      date_result_type r;
      int unsigned y, m, d, lim;
      logic leap;
      r.status = STATUS_INVALID;
      r.year = '0;
      r.month = '0;
      r.day = '0;
      if (scan_phase == PH_START) begin
         r.status = STATUS_KEEP;
      end else if (scan_phase == PH_DONE || (scan_phase == PH_NUM && field_count == 2'd2)) begin
         case (order_setting)
            ORDER_DMY: begin
               d = first_value; m = second_value; y = digits_value;
            end
            ORDER_YMD: begin
               y = first_value; m = second_value; d = digits_value;
            end
            default: begin
               m = first_value; d = second_value; y = digits_value;
            end
         endcase
         if (y <= 99) y += (y >= 80) ? 1900 : 2000;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         case (m)
            2:              lim = leap ? 29 : 28;
            4, 6, 9, 11:    lim = 30;
            1, 3, 5, 7, 8, 10, 12: lim = 31;
            default:        lim = 0;
         endcase
         if (d >= 1 && d <= lim && y >= 1980 && y <= 2099) begin
            r.status = STATUS_VALID;
            r.year = y[YEAR_W-1:0];
            r.month = m[MONTH_W-1:0];
            r.day = d[DAY_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic predict_char(input logic [CH_W-1:0] c);
      logic is_digit;
      logic [NUM_W-1:0] dv;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      dv = {8'h00, c - CHAR_ZERO};
      if (c == CHAR_NUL) begin
         expected_dates.push_back(judge_date());
         clear_scan();
      end else begin
         case (scan_phase)
            PH_START, PH_SEP: begin
               if (is_digit) begin
                  digits_value = dv;
                  scan_phase = PH_NUM;
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_NUM: begin
               if (is_digit) begin
                  digits_value = digits_value * 16'd10 + dv;
               end else if (field_count == 2'd2) begin
                  scan_phase = PH_DONE;
               end else if (c == CHAR_SLASH || c == CHAR_DASH || c == separator_setting) begin
                  if (field_count == 2'd0) first_value = digits_value;
                  else second_value = digits_value;
                  field_count = field_count + 2'd1;
                  digits_value = '0;
                  scan_phase = PH_SEP;
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      date_result_type want;
      if (reset) begin
         clear_scan();
      end else begin
         if (req_valid && !req_stall) predict_char(req_ch);
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               note_failure($sformatf("unexpected result: status %0d year %0d month %0d day %0d",
                                      rsp_status, rsp_year, rsp_month, rsp_day));
            end else begin
               want = expected_dates.pop_front();
               if (rsp_status !== want.status || rsp_year !== want.year ||
                   rsp_month !== want.month || rsp_day !== want.day)
                  note_failure($sformatf(
                     "mismatch: expected %0d %0d-%0d-%0d, got %0d %0d-%0d-%0d",
                     want.status, want.year, want.month, want.day,
                     rsp_status, rsp_year, rsp_month, rsp_day));
            end
         end
      end
   end

   initial begin : receiver
      stall_mode_type mode;
      int mode_left, hold_left;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   task automatic send_char(input logic [CH_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      chars_sent++;
      req_valid <= 1'b1;
      req_ch <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_string(input string s);
      send_chars(s);
      send_char(CHAR_NUL);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CH_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_DATE_ORDER) order_setting = data[ORDER_W-1:0];
      else separator_setting = data;
      @(posedge clock);
   endtask

   function automatic int unsigned pick_value(input date_role_type role);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 99999);
      case (role)
         ROLE_MONTH: return $urandom_range(0, 13);
         ROLE_DAY:   return $urandom_range(0, 1) ? $urandom_range(27, 32) : $urandom_range(0, 32);
         default:    return $urandom_range(0, 1) ? $urandom_range(0, 99)
                                                 : $urandom_range(1975, 2105);
      endcase
   endfunction

   function automatic logic [CH_W-1:0] pick_separator();
      case ($urandom_range(0, 2))
         0:       return CHAR_SLASH;
         1:       return CHAR_DASH;
         default: return (separator_setting == CHAR_NUL) ? CHAR_SLASH : separator_setting;
      endcase
   endfunction

   task automatic append_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) string_chars.push_back(CHAR_ZERO);
      for (int i = 0; i < s.len(); i++) string_chars.push_back(s[i]);
   endtask

   task automatic send_random_string();
      date_role_type roles[3];
      int kind;
      case (order_setting)
         ORDER_DMY: roles = '{ROLE_DAY, ROLE_MONTH, ROLE_YEAR};
         ORDER_YMD: roles = '{ROLE_YEAR, ROLE_MONTH, ROLE_DAY};
         default:   roles = '{ROLE_MONTH, ROLE_DAY, ROLE_YEAR};
      endcase
      string_chars.delete();
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
         for (int i = 0; i < 3; i++) begin
            append_number(pick_value(roles[i]));
            if (i < 2) string_chars.push_back(pick_separator());
         end
         if (kind >= 12)
            repeat ($urandom_range(1, 4)) string_chars.push_back(8'($urandom_range(1, 255)));
         if (kind == 13)
            string_chars.delete($urandom_range(0, string_chars.size() - 1));
         if (kind == 14)
            string_chars[$urandom_range(0, string_chars.size() - 1)] = 8'($urandom_range(1, 255));
      end else if (kind < 18) begin
         repeat ($urandom_range(0, 6)) string_chars.push_back(8'($urandom_range(1, 255)));
      end else begin
         append_number(pick_value(roles[0]));
         if (kind == 19) begin
            string_chars.push_back(pick_separator());
            append_number(pick_value(roles[1]));
         end
      end
      foreach (string_chars[i]) send_char(string_chars[i]);
      send_char(CHAR_NUL);
   endtask

   task automatic test_default_format();
      send_string("12/31/1999");
      send_string("");
      send_string("2/29/2000");
      send_string("2/29/2024");
      send_string("2/29/2023");
      send_string("2/29/2100");
      send_string("13/1/2000");
      send_string("0/1/2000");
      send_string("1/0/2000");
      send_string("1/32/2000");
      send_string("4/31/2001");
      send_string("12-31-79");
      send_string("1-1-80");
      send_string("1/1/99");
      send_string("1/1/1979");
      send_string("12/31/2099");
      send_string("1/1/2100");
      send_string("1//2000");
      send_string("1/2");
      send_string("/1/2/2000");
      send_string("1/2/2000 xyz");
      send_string("1.2.2000");
      send_string("65537/1/2000");
      send_string("001/0002/00099");
      send_chars("1/1/2000");
      send_char(8'hff);
      send_char(CHAR_NUL);
      send_char(8'hff);
      send_char(CHAR_NUL);
      wait_idle();
   endtask

   task automatic test_field_orders();
      write_csr(CSR_DATE_ORDER, ORDER_DMY);
      send_string("31/12/1999");
      send_string("29-2-2000");
      send_string("12/31/1999");
      wait_idle();
      write_csr(CSR_DATE_ORDER, ORDER_YMD);
      send_string("2024/2/29");
      send_string("99-12-31");
      send_string("1980/1/1");
      wait_idle();
      write_csr(CSR_DATE_ORDER, 8'd3);
      send_string("12/31/1999");
      send_string("31/12/1999");
      wait_idle();
      write_csr(CSR_DATE_ORDER, ORDER_MDY);
   endtask

   task automatic test_separators();
      write_csr(CSR_SEPARATOR, ".");
      send_string("1.2.2000");
      send_string("1/2-2000");
      wait_idle();
      write_csr(CSR_SEPARATOR, "5");
      send_string("1/5/2000");
      send_string("152000");
      wait_idle();
      write_csr(CSR_SEPARATOR, 8'h00);
      send_string("3-4/2005");
      wait_idle();
      write_csr(CSR_SEPARATOR, 8'hff);
      send_chars("7");
      send_char(8'hff);
      send_chars("8");
      send_char(8'hff);
      send_string("2010");
      wait_idle();
      write_csr(CSR_SEPARATOR, " ");
      send_string("1 2 2000");
      wait_idle();
      write_csr(CSR_SEPARATOR, SEP_RESET);
   endtask

   task automatic test_mid_string_config();
      send_chars("12/31/");
      wait_idle();
      write_csr(CSR_DATE_ORDER, ORDER_DMY);
      send_string("1999");
      wait_idle();
      write_csr(CSR_DATE_ORDER, ORDER_MDY);
      send_chars("3");
      wait_idle();
      write_csr(CSR_SEPARATOR, ".");
      send_string(".4.2001");
      wait_idle();
      write_csr(CSR_SEPARATOR, SEP_RESET);
   endtask

   task automatic test_backpressure();
      hold_request = LONG_HOLD;
      repeat (12) send_random_string();
      wait_idle();
      repeat (6) send_random_string();
      wait_idle();
   endtask

   task automatic test_random();
      int target;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_csr(CSR_DATE_ORDER, (p < 4) ? 8'(p) : 8'($urandom_range(0, 3)));
         case (p)
            0:       write_csr(CSR_SEPARATOR, 8'hff);
            1:       write_csr(CSR_SEPARATOR, 8'h00);
            2:       write_csr(CSR_SEPARATOR, 8'(CHAR_ZERO + $urandom_range(0, 9)));
            3:       write_csr(CSR_SEPARATOR, SEP_RESET);
            default: write_csr(CSR_SEPARATOR, 8'($urandom_range(0, 255)));
         endcase
         target = chars_sent + RANDOM_ITEMS / 8;
         while (chars_sent < target) send_random_string();
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = CHAR_NUL;
      csr_wr_en = 1'b0;
      csr_index = CSR_DATE_ORDER;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_format();
      test_field_orders();
      test_separators();
      test_mid_string_config();
      test_backpressure();
      test_random();
      wait_idle();
      if (expected_dates.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_dates.size()));
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
